FILE: hw/rtl/cubic_bezier_point_eval_defines.svh
// Assertion macros for the cubic Bezier point evaluator checker.
// Needs clk and rst_n in the scope of each use.
`ifndef CUBIC_BEZIER_POINT_EVAL_DEFINES_SVH
`define CUBIC_BEZIER_POINT_EVAL_DEFINES_SVH

// Check cons in the same cycle as ante.
`define CBPE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbpe check failed");

// Check cons in the cycle after ante.
`define CBPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbpe check failed");

`endif

FILE: hw/rtl/cbpe_pkg.sv
// Shared types and constants for the cubic Bezier point evaluator.
// No dependencies.
package cbpe_pkg;

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_REG_COUNT = 8;

  // Register stages from input beat to output register inclusive.
  localparam int CBPE_LATENCY  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X      = 3'd0,
    REG_START_Y      = 3'd1,
    REG_HANDLE_ONE_X = 3'd2,
    REG_HANDLE_ONE_Y = 3'd3,
    REG_HANDLE_TWO_X = 3'd4,
    REG_HANDLE_TWO_Y = 3'd5,
    REG_END_X        = 3'd6,
    REG_END_Y        = 3'd7
  } cfg_reg_t;

endpackage

FILE: hw/rtl/cubic_bezier_point_eval.sv
// Top level of the cubic Bezier point evaluator: registers, clamp, three levels, rounding.
// Depends on cbpe_pkg and cbpe_lerp_lvl.
//
// Usage:
//   Write the four control points (signed Q16.16 x and y) through cfg_wr_en,
//   cfg_index and cfg_data while no beat is in flight; a write lands at once.
//   Each input beat carries t in Q1.16; a value above 1.0 is taken as 1.0.
//   Each input beat gives exactly one output beat with the curve point,
//   rounded to nearest, ties towards plus infinity.
//   Pipeline: eight register stages (clamp, two stages per curve level,
//   rounding output register) carry each accepted beat to the output.
//   Throughput: one beat per cycle unless stalled; the whole pipeline advances together.
//   Stall: when out_valid is high and out_ready low, every stage holds and
//   in_ready drops in the same cycle; nothing is lost or repeated.
//   Reset: synchronous rst_n clears all valid bits and the control points to 0.
module cubic_bezier_point_eval #(
  parameter int COORD_WIDTH     = 32,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [cbpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [PARAM_FRAC_BITS:0]          in_curve_param,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COORD_WIDTH-1:0]     out_point_x,
  output logic signed [COORD_WIDTH-1:0]     out_point_y
);

  import cbpe_pkg::*;

  localparam int TW    = PARAM_FRAC_BITS + 1;
  localparam int W1    = COORD_WIDTH + PARAM_FRAC_BITS;
  localparam int W2    = COORD_WIDTH + 2 * PARAM_FRAC_BITS;
  localparam int ACC_W = COORD_WIDTH + 3 * PARAM_FRAC_BITS;
  localparam int TAPS  = 5;

  localparam logic [TW-1:0]          T_ONE    = TW'(1) << PARAM_FRAC_BITS;
  localparam logic [COORD_WIDTH-1:0] SIGN_BIT = COORD_WIDTH'(1) << (COORD_WIDTH - 1);
  localparam logic [ACC_W-1:0]       RND_HALF = ACC_W'(1) << (3 * PARAM_FRAC_BITS - 1);

  logic [COORD_WIDTH-1:0]    ctl_r [CFG_REG_COUNT];
  logic [CBPE_LATENCY-1:0]   vld_r, vld_nxt;
  logic [TW-1:0]             t_r [TAPS];
  logic [TW-1:0]             u_r [TAPS];
  logic [TW-1:0]             t_nxt, u_nxt;
  logic [COORD_WIDTH-1:0]    out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                      en;

  logic [3:0][COORD_WIDTH-1:0] qx, qy;
  logic [2:0][W1-1:0]          x1, y1;
  logic [1:0][W2-1:0]          x2, y2;
  logic [0:0][ACC_W-1:0]       x3, y3;
  logic [ACC_W-1:0]            rnd_x, rnd_y;

  assign en       = !vld_r[CBPE_LATENCY-1] || out_ready;
  assign in_ready = en;

  // hold control points
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_REG_COUNT; i++) ctl_r[i] <= '0;
    end else if (cfg_wr_en) begin
      ctl_r[cfg_index] <= cfg_data;
    end
  end

  // advance valid bits
  assign vld_nxt = {vld_r[CBPE_LATENCY-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // clamp t to 1.0
  always_comb begin
    t_nxt = (in_curve_param > T_ONE) ? T_ONE : in_curve_param;
    u_nxt = T_ONE - t_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= t_nxt;
      u_r[0] <= u_nxt;
      for (int k = 1; k < TAPS; k++) begin
        t_r[k] <= t_r[k-1];
        u_r[k] <= u_r[k-1];
      end
    end
  end

  // offset coordinates into unsigned range
  always_comb begin
    qx[0] = ctl_r[REG_START_X]      ^ SIGN_BIT;
    qx[1] = ctl_r[REG_HANDLE_ONE_X] ^ SIGN_BIT;
    qx[2] = ctl_r[REG_HANDLE_TWO_X] ^ SIGN_BIT;
    qx[3] = ctl_r[REG_END_X]        ^ SIGN_BIT;
    qy[0] = ctl_r[REG_START_Y]      ^ SIGN_BIT;
    qy[1] = ctl_r[REG_HANDLE_ONE_Y] ^ SIGN_BIT;
    qy[2] = ctl_r[REG_HANDLE_TWO_Y] ^ SIGN_BIT;
    qy[3] = ctl_r[REG_END_Y]        ^ SIGN_BIT;
  end

  cbpe_lerp_lvl #(.NUM_IN(4), .VAL_WIDTH(COORD_WIDTH), .FRAC_BITS(PARAM_FRAC_BITS)) u_lvl1_x (
    .clk(clk), .en(en), .t_val(t_r[0]), .u_val(u_r[0]), .val_in(qx), .val_out(x1)
  );
  cbpe_lerp_lvl #(.NUM_IN(4), .VAL_WIDTH(COORD_WIDTH), .FRAC_BITS(PARAM_FRAC_BITS)) u_lvl1_y (
    .clk(clk), .en(en), .t_val(t_r[0]), .u_val(u_r[0]), .val_in(qy), .val_out(y1)
  );
  cbpe_lerp_lvl #(.NUM_IN(3), .VAL_WIDTH(W1), .FRAC_BITS(PARAM_FRAC_BITS)) u_lvl2_x (
    .clk(clk), .en(en), .t_val(t_r[2]), .u_val(u_r[2]), .val_in(x1), .val_out(x2)
  );
  cbpe_lerp_lvl #(.NUM_IN(3), .VAL_WIDTH(W1), .FRAC_BITS(PARAM_FRAC_BITS)) u_lvl2_y (
    .clk(clk), .en(en), .t_val(t_r[2]), .u_val(u_r[2]), .val_in(y1), .val_out(y2)
  );
  cbpe_lerp_lvl #(.NUM_IN(2), .VAL_WIDTH(W2), .FRAC_BITS(PARAM_FRAC_BITS)) u_lvl3_x (
    .clk(clk), .en(en), .t_val(t_r[4]), .u_val(u_r[4]), .val_in(x2), .val_out(x3)
  );
  cbpe_lerp_lvl #(.NUM_IN(2), .VAL_WIDTH(W2), .FRAC_BITS(PARAM_FRAC_BITS)) u_lvl3_y (
    .clk(clk), .en(en), .t_val(t_r[4]), .u_val(u_r[4]), .val_in(y2), .val_out(y3)
  );

  // round, drop fraction, restore sign
  always_comb begin
    rnd_x     = x3[0] + RND_HALF;
    rnd_y     = y3[0] + RND_HALF;
    out_x_nxt = rnd_x[ACC_W-1 -: COORD_WIDTH] ^ SIGN_BIT;
    out_y_nxt = rnd_y[ACC_W-1 -: COORD_WIDTH] ^ SIGN_BIT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= out_x_nxt;
      out_y_r <= out_y_nxt;
    end
  end

  assign out_valid   = vld_r[CBPE_LATENCY-1];
  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;

endmodule

FILE: hw/rtl/cbpe_lerp_lvl.sv
// One exact de Casteljau level: out[j] = in[j]*u + in[j+1]*t, two register stages.
// Stage A holds split partial products, stage B their sum. No package use.
module cbpe_lerp_lvl #(
  parameter int NUM_IN    = 4,
  parameter int VAL_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [FRAC_BITS:0]                            t_val,
  input  logic [FRAC_BITS:0]                            u_val,
  input  logic [NUM_IN-1:0][VAL_WIDTH-1:0]              val_in,
  output logic [NUM_IN-2:0][VAL_WIDTH+FRAC_BITS-1:0]    val_out
);

  localparam int TW      = FRAC_BITS + 1;
  localparam int LO_W    = (VAL_WIDTH + 1) / 2;
  localparam int HI_W    = VAL_WIDTH - LO_W;
  localparam int OUT_W   = VAL_WIDTH + FRAC_BITS;
  localparam int SUM_W   = VAL_WIDTH + TW;
  localparam int NUM_OUT = NUM_IN - 1;

  logic [NUM_OUT-1:0][LO_W+TW-1:0] ul_r, ul_nxt, tl_r, tl_nxt;
  logic [NUM_OUT-1:0][HI_W+TW-1:0] uh_r, uh_nxt, th_r, th_nxt;
  logic [NUM_OUT-1:0][OUT_W-1:0]   sum_r, sum_nxt;

  always_comb begin
    for (int j = 0; j < NUM_OUT; j++) begin
      ul_nxt[j] = {{TW{1'b0}}, val_in[j][LO_W-1:0]} * {{LO_W{1'b0}}, u_val};
      uh_nxt[j] = {{TW{1'b0}}, val_in[j][VAL_WIDTH-1:LO_W]} * {{HI_W{1'b0}}, u_val};
      tl_nxt[j] = {{TW{1'b0}}, val_in[j+1][LO_W-1:0]} * {{LO_W{1'b0}}, t_val};
      th_nxt[j] = {{TW{1'b0}}, val_in[j+1][VAL_WIDTH-1:LO_W]} * {{HI_W{1'b0}}, t_val};
    end
  end

  always_comb begin
    logic [SUM_W-1:0] acc;
    for (int j = 0; j < NUM_OUT; j++) begin
      acc = {uh_r[j], {LO_W{1'b0}}} + {th_r[j], {LO_W{1'b0}}}
          + {{HI_W{1'b0}}, ul_r[j]} + {{HI_W{1'b0}}, tl_r[j]};
      sum_nxt[j] = acc[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ul_r  <= ul_nxt;
      uh_r  <= uh_nxt;
      tl_r  <= tl_nxt;
      th_r  <= th_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign val_out = sum_r;

endmodule

FILE: hw/rtl/cbpe_checker.sv
// Port-level checker for the cubic Bezier point evaluator, with its bind.
// Depends on cbpe_pkg and cubic_bezier_point_eval_defines.svh.
`include "cubic_bezier_point_eval_defines.svh"

module cbpe_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_point_x,
  input logic [COORD_WIDTH-1:0] out_point_y
);

  import cbpe_pkg::*;

  // a stalled result holds
  `CBPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_point_x) && $stable(out_point_y))

  // an empty output register never blocks the input
  `CBPE_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

  // with no stall the result shows after the full pipeline
  `CBPE_ASSERT_NEXT(a_latency,
    $past(in_valid && in_ready && rst_n, CBPE_LATENCY - 1) &&
    $past(in_ready && rst_n, 6) && $past(in_ready && rst_n, 5) &&
    $past(in_ready && rst_n, 4) && $past(in_ready && rst_n, 3) &&
    $past(in_ready && rst_n, 2) && $past(in_ready && rst_n, 1) && in_ready,
    out_valid)

endmodule

bind cubic_bezier_point_eval cbpe_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cbpe_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_point_x(out_point_x),
  .out_point_y(out_point_y)
);
